// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define AST_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/tkn_pkg.sv =====
package tkn_pkg;

  localparam int MAX_KEEP_DEF = 16;
  localparam int KEEP_W = 5;
  localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd16;

  localparam logic CMD_OFFER = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] distance;
  } cand_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     valid;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DRAIN,
    ST_EMPTY
  } state_t;

  function automatic logic cand_less(input cand_t a, input cand_t b);
    return {a.distance, a.id} < {b.distance, b.id};
  endfunction

endpackage

// ===== rtl/tkn_cell.sv =====
module tkn_cell (
  input  logic              clk,
  input  tkn_pkg::cell_ctl_t ctl,
  input  tkn_pkg::cand_t    new_cand,
  input  tkn_pkg::cand_t    left_cand,
  input  logic              left_lt,
  input  tkn_pkg::cand_t    right_cand,
  output tkn_pkg::cand_t    cand_q,
  output logic              lt
);
  import tkn_pkg::*;

  cand_t cand_r;
  cand_t cand_nxt;

  assign lt     = !ctl.valid || cand_less(new_cand, cand_r);
  assign cand_q = cand_r;

  always_comb begin
    cand_nxt = cand_r;
    unique case (ctl.op)
      CELL_HOLD:   cand_nxt = cand_r;
      CELL_INSERT: begin
        if (lt) begin
          cand_nxt = left_lt ? left_cand : new_cand;
        end
      end
      CELL_SHIFT:  cand_nxt = right_cand;
      default:     cand_nxt = cand_r;
    endcase
  end

  always_ff @(posedge clk) begin
    cand_r <= cand_nxt;
  end

endmodule

// ===== rtl/top_k_nearest_selector.sv =====
// Keeps the nearest candidates of one search and hands them out sorted.
// Input channel: in_tdata carries distance and candidate id, in_tuser[0] the
// command (0 offer, 1 flush). Output channel: out_tdata carries distance and
// id in ascending order, out_tlast marks the final item of a flush and
// out_tuser flags the single item of a flush that found nothing held.
// cfg_wr_en/cfg_wr_data set keep_count (0 acts as 1, above MAX_KEEP as
// MAX_KEEP); write it only while the block is idle.
// Offers are taken one per cycle while the block is idle: a row of MAX_KEEP
// cells holds the list sorted and inserts the new candidate as the offer is
// taken, dropping the worst when full. A flush of n held candidates moves
// the block into its drain state, which emits one item per cycle from the
// head of the row; in_tready stays low until the last item (or the single
// empty item) is loaded. Results sit in an output register, so a stall on
// out_tready holds the drain and the item in place. Reset empties the list
// and sets keep_count to 16; the store needs no clearing pass.
module top_k_nearest_selector #(
  parameter int MAX_KEEP = tkn_pkg::MAX_KEEP_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,    // distance[31:0], cand_id[63:32]
  input  logic [0:0]  in_tuser,    // cmd[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // out_distance[31:0], out_id[63:32]
  output logic        out_tlast,
  output logic [0:0]  out_tuser,   // empty_res[0]
  input  logic        cfg_wr_en,
  input  logic [tkn_pkg::KEEP_W-1:0] cfg_wr_data
);
  import tkn_pkg::*;

  localparam int CW = $clog2(MAX_KEEP + 1);
  localparam int LW = (CW > KEEP_W) ? CW : KEEP_W;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [KEEP_W-1:0]    keep_r;
  logic                 out_valid_r;
  cand_t                out_cand_r;
  logic                 out_last_r;
  logic                 out_empty_r;

  cand_t                new_cand;
  cand_t                cell_q  [MAX_KEEP];
  logic                 cell_lt [MAX_KEEP];
  cell_ctl_t            cell_ctl[MAX_KEEP];
  cell_op_t             op;
  logic                 in_acc, offer, flush, out_free, load_out, append;
  logic [LW-1:0]        keep_ext, limit;

  assign new_cand.distance = in_tdata[31:0];
  assign new_cand.id       = in_tdata[63:32];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign offer     = in_acc && (in_tuser[0] == CMD_OFFER);
  assign flush     = in_acc && (in_tuser[0] == CMD_FLUSH);
  assign out_free  = !out_valid_r || out_tready;

  assign keep_ext = LW'(keep_r);
  always_comb begin
    limit = keep_ext;
    if (keep_ext == '0) begin
      limit = LW'(1);
    end else if (keep_ext > LW'(MAX_KEEP)) begin
      limit = LW'(MAX_KEEP);
    end
  end
  assign append = LW'(count_r) < limit;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (flush) begin
          state_nxt = (count_r == '0) ? ST_EMPTY : ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_free && (count_r == CW'(1))) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    op        = CELL_HOLD;
    load_out  = 1'b0;
    count_nxt = count_r;
    unique case (state_r)
      ST_IDLE: begin
        if (offer) begin
          op = CELL_INSERT;
          if (append) begin
            count_nxt = count_r + CW'(1);
          end
        end
      end
      ST_DRAIN: begin
        if (out_free) begin
          op        = CELL_SHIFT;
          load_out  = 1'b1;
          count_nxt = count_r - CW'(1);
        end
      end
      ST_EMPTY: load_out = out_free;
      default:  op = CELL_HOLD;
    endcase
  end

  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    assign cell_ctl[i].op    = op;
    assign cell_ctl[i].valid = (CW'(i) < count_r);

    tkn_cell u_cell (
      .clk        (clk),
      .ctl        (cell_ctl[i]),
      .new_cand   (new_cand),
      .left_cand  ((i == 0) ? new_cand : cell_q[(i == 0) ? 0 : i - 1]),
      .left_lt    ((i == 0) ? 1'b0 : cell_lt[(i == 0) ? 0 : i - 1]),
      .right_cand ((i == MAX_KEEP - 1) ? new_cand
                                       : cell_q[(i == MAX_KEEP - 1) ? i : i + 1]),
      .cand_q     (cell_q[i]),
      .lt         (cell_lt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      keep_r      <= KEEP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (cfg_wr_en) begin
        keep_r <= cfg_wr_data;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if (state_r == ST_EMPTY) begin
        out_cand_r  <= '0;
        out_last_r  <= 1'b1;
        out_empty_r <= 1'b1;
      end else begin
        out_cand_r  <= cell_q[0];
        out_last_r  <= (count_r == CW'(1));
        out_empty_r <= 1'b0;
      end
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {out_cand_r.id, out_cand_r.distance};
  assign out_tlast    = out_last_r;
  assign out_tuser[0] = out_empty_r;

endmodule

// ===== rtl/tkn_checker.sv =====
`include "assert_macros.svh"

module tkn_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [63:0] in_tdata,
  input logic [0:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic        out_tlast,
  input logic [0:0]  out_tuser,
  input logic        cfg_wr_en,
  input logic [tkn_pkg::KEEP_W-1:0] cfg_wr_data
);
  import tkn_pkg::*;

  logic        flush_acc;
  logic [65:0] out_word;
  assign flush_acc = in_tvalid && in_tready && (in_tuser[0] == CMD_FLUSH);
  assign out_word  = {out_tuser, out_tlast, out_tdata};

  // hold a stalled result
  `AST_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_word))
  `AST_IMPL(a_empty_last, out_tvalid && out_tuser[0], out_tlast)
  `AST_IMPL(a_empty_zero, out_tvalid && out_tuser[0], out_tdata == 64'd0)
  `AST_NEXT(a_flush_busy, flush_acc, !in_tready)

endmodule

bind top_k_nearest_selector tkn_checker u_tkn_checker (.*);
